### src/nwas_pkg.sv
// Package for the next weekly alarm selector.
// Shared constants and the classified alarm record; no dependencies.
`default_nettype none

package nwas_pkg;

    localparam int DAYS_PER_WEEK  = 7;
    localparam int COUNT_W        = 7;
    localparam int MAX_ALARMS_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    // Weekday code that stands for the last day of the week
    localparam logic [2:0] DAY_ZERO = 3'd0;

    // One alarm after classification
    typedef struct packed {
        logic       active;
        logic [5:0] id;
        logic [6:0] mask;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [2:0] flags;
        logic [2:0] days;
        logic       last;
    } t_alarm_item;

endpackage

`default_nettype wire

### src/nwas_front.sv
// Front end: classifies one alarm (active or skipped, days until it fires).
// Depends on nwas_pkg.
`default_nettype none

module nwas_front (
    input  wire logic [5:0]         i_alarm_id,
    input  wire logic               i_enabled,
    input  wire logic [6:0]         i_day_mask,
    input  wire logic [7:0]         i_alarm_hour,
    input  wire logic [7:0]         i_alarm_minute,
    input  wire logic [2:0]         i_alarm_flags,
    input  wire logic [2:0]         i_now_day,
    input  wire logic [7:0]         i_now_hour,
    input  wire logic [7:0]         i_now_minute,
    input  wire logic               i_last,
    output nwas_pkg::t_alarm_item   o_item
);
    import nwas_pkg::*;

    logic [2:0]  today_idx;
    logic        later;
    logic [13:0] dbl_mask;
    logic [6:0]  rot_mask;
    logic [2:0]  days;

    // Weekday index 0..6, day code zero counts as the last weekday
    assign today_idx = (i_now_day == DAY_ZERO) ? 3'(DAYS_PER_WEEK - 1) : i_now_day - 3'd1;

    // Strictly later than now today
    assign later = (i_alarm_hour > i_now_hour) ||
                   ((i_alarm_hour == i_now_hour) && (i_alarm_minute > i_now_minute));

    // Rotate so bit 0 is today
    assign dbl_mask = {i_day_mask, i_day_mask} >> today_idx;
    assign rot_mask = dbl_mask[6:0];

    // Priority encode from tomorrow on; only today left means next week
    always_comb begin
        days = 3'(DAYS_PER_WEEK);
        for (int k = DAYS_PER_WEEK - 1; k >= 1; k--) begin
            if (rot_mask[k]) begin
                days = 3'(k);
            end
        end
        if (rot_mask[0] && later) begin
            days = 3'd0;
        end
    end

    always_comb begin
        o_item.active = i_enabled && (i_day_mask != 7'd0);
        o_item.id     = i_alarm_id;
        o_item.mask   = i_day_mask;
        o_item.hour   = i_alarm_hour;
        o_item.minute = i_alarm_minute;
        o_item.flags  = i_alarm_flags;
        o_item.days   = days;
        o_item.last   = i_last;
    end

endmodule

`default_nettype wire

### src/nwas_queue.sv
// Short register queue between the front and back ends.
// Depends on nwas_pkg.
`default_nettype none

module nwas_queue #(
    parameter int DEPTH = nwas_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire nwas_pkg::t_alarm_item i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output nwas_pkg::t_alarm_item   o_data
);
    import nwas_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_alarm_item       r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### src/nwas_back.sv
// Back end: keeps the soonest alarm and the active count, emits the result.
// Depends on nwas_pkg.
`default_nettype none

module nwas_back #(
    parameter int MAX_ALARMS = nwas_pkg::MAX_ALARMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire nwas_pkg::t_alarm_item         i_item,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [nwas_pkg::COUNT_W-1:0]       o_active_count,
    output logic                               o_found,
    output logic [5:0]                         o_next_id,
    output logic [6:0]                         o_next_day_mask,
    output logic [7:0]                         o_next_hour,
    output logic [7:0]                         o_next_minute,
    output logic [2:0]                         o_next_flags,
    output logic [2:0]                         o_days_ahead
);
    import nwas_pkg::*;

    logic               r_best_valid, n_best_valid;
    logic [5:0]         r_best_id, n_best_id;
    logic [6:0]         r_best_mask, n_best_mask;
    logic [7:0]         r_best_hour, n_best_hour;
    logic [7:0]         r_best_minute, n_best_minute;
    logic [2:0]         r_best_flags, n_best_flags;
    logic [2:0]         r_best_days, n_best_days;
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_out_valid;
    logic               out_free;
    logic               take;

    // A last item needs the output slot free or draining
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_empty && (!i_item.last || out_free);
    assign o_valid  = r_out_valid;

    // Three-key compare, ties go to the newer alarm
    assign take = !r_best_valid ||
                  (i_item.days < r_best_days) ||
                  ((i_item.days == r_best_days) &&
                   ((i_item.hour < r_best_hour) ||
                    ((i_item.hour == r_best_hour) && (i_item.minute <= r_best_minute))));

    // Updated best and count including the head item
    always_comb begin
        n_best_valid  = r_best_valid;
        n_best_id     = r_best_id;
        n_best_mask   = r_best_mask;
        n_best_hour   = r_best_hour;
        n_best_minute = r_best_minute;
        n_best_flags  = r_best_flags;
        n_best_days   = r_best_days;
        n_total       = r_total;
        if (i_item.active) begin
            if (r_total < COUNT_W'(MAX_ALARMS)) begin
                n_total = r_total + 1'b1;
            end
            if (take) begin
                n_best_valid  = 1'b1;
                n_best_id     = i_item.id;
                n_best_mask   = i_item.mask;
                n_best_hour   = i_item.hour;
                n_best_minute = i_item.minute;
                n_best_flags  = i_item.flags;
                n_best_days   = i_item.days;
            end
        end
    end

    // Running state, cleared after the last item of a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid  <= 1'b0;
            r_best_id     <= '0;
            r_best_mask   <= '0;
            r_best_hour   <= '0;
            r_best_minute <= '0;
            r_best_flags  <= '0;
            r_best_days   <= '0;
            r_total       <= '0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_best_valid  <= 1'b0;
                r_best_id     <= '0;
                r_best_mask   <= '0;
                r_best_hour   <= '0;
                r_best_minute <= '0;
                r_best_flags  <= '0;
                r_best_days   <= '0;
                r_total       <= '0;
            end else begin
                r_best_valid  <= n_best_valid;
                r_best_id     <= n_best_id;
                r_best_mask   <= n_best_mask;
                r_best_hour   <= n_best_hour;
                r_best_minute <= n_best_minute;
                r_best_flags  <= n_best_flags;
                r_best_days   <= n_best_days;
                r_total       <= n_total;
            end
        end
    end

    // Output slot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            o_active_count  <= n_total;
            o_found         <= n_best_valid;
            o_next_id       <= n_best_id;
            o_next_day_mask <= n_best_mask;
            o_next_hour     <= n_best_hour;
            o_next_minute   <= n_best_minute;
            o_next_flags    <= n_best_flags;
            o_days_ahead    <= n_best_days;
        end
    end

endmodule

`default_nettype wire

### src/next_weekly_alarm_select_top.sv
// Next weekly alarm selector, top level.
// Instantiates nwas_front, nwas_queue and nwas_back; depends on nwas_pkg.
//
// Usage: a scan is a run of alarm transfers on the input channel, each
// carrying one alarm entry and the current weekday, hour and minute. The
// transfer marked last closes the scan and produces one result transfer:
// the count of active alarms and the soonest alarm with its days ahead.
// Other transfers produce no result.
// Channels: valid/stall on both sides. A transfer happens at a clock edge
// with valid high and stall low.
// Throughput: one alarm per cycle while input stall is low; the classify
// logic and the compare against the kept best are each combinational.
// Result path: a taken last transfer is written into the two-entry queue;
// the back end then pops it and loads the output register once the slot
// is free or draining.
// Output stall: the result holds in the output register; the back end
// keeps folding non-last alarms in, and input stall rises only once the
// queue fills behind a waiting last alarm.
// Reset: synchronous, active low; clears the queue, the running best and
// count, and the output valid.
`default_nettype none

module next_weekly_alarm_select_top #(
    parameter int MAX_ALARMS = nwas_pkg::MAX_ALARMS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [5:0]               i_alarm_id,
    input  wire logic                     i_enabled,
    input  wire logic [6:0]               i_day_mask,
    input  wire logic [7:0]               i_alarm_hour,
    input  wire logic [7:0]               i_alarm_minute,
    input  wire logic [2:0]               i_alarm_flags,
    input  wire logic [2:0]               i_now_day,
    input  wire logic [7:0]               i_now_hour,
    input  wire logic [7:0]               i_now_minute,
    input  wire logic                     i_last,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [nwas_pkg::COUNT_W-1:0]  o_active_count,
    output logic                          o_found,
    output logic [5:0]                    o_next_id,
    output logic [6:0]                    o_next_day_mask,
    output logic [7:0]                    o_next_hour,
    output logic [7:0]                    o_next_minute,
    output logic [2:0]                    o_next_flags,
    output logic [2:0]                    o_days_ahead
);
    import nwas_pkg::*;

    t_alarm_item front_item;
    t_alarm_item head_item;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    assign o_stall = q_full;

    // Classify incoming alarm
    nwas_front u_front (
        .i_alarm_id     (i_alarm_id),
        .i_enabled      (i_enabled),
        .i_day_mask     (i_day_mask),
        .i_alarm_hour   (i_alarm_hour),
        .i_alarm_minute (i_alarm_minute),
        .i_alarm_flags  (i_alarm_flags),
        .i_now_day      (i_now_day),
        .i_now_hour     (i_now_hour),
        .i_now_minute   (i_now_minute),
        .i_last         (i_last),
        .o_item         (front_item)
    );

    // Decoupling queue
    nwas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_item)
    );

    // Selection and result
    nwas_back #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (head_item),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_active_count  (o_active_count),
        .o_found         (o_found),
        .o_next_id       (o_next_id),
        .o_next_day_mask (o_next_day_mask),
        .o_next_hour     (o_next_hour),
        .o_next_minute   (o_next_minute),
        .o_next_flags    (o_next_flags),
        .o_days_ahead    (o_days_ahead)
    );

endmodule

`default_nettype wire
